// ===== sv/bblur_pkg.sv =====
`default_nettype none

package bblur_pkg;

  localparam int PIX_W     = 8;
  localparam int RGB_W     = 3 * PIX_W;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = 12;
  localparam int NUM_W     = SUM_W + 1;
  localparam int CNT_W     = 4;
  localparam int RCP_K     = 18;
  localparam int RCP_W     = 18;
  localparam int PROD_W    = NUM_W + RCP_W;

  typedef logic [RGB_W-1:0] rgb_t;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } in_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             last_pixel;
  } out_res_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic emit;
    logic has_left;
    logic has_right;
    logic top;
    logic bottom;
    logic last;
  } win_ctrl_t;

  // ceil(2^RCP_K / (2*n)) for every neighbor count that can occur
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RCP_W-1:0] m;
    case (n)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== sv/box_blur_3x3_edge_aware.sv =====
// 3x3 edge-aware box blur on a raster RGB stream.
// Input channel (in_valid/in_ready/in_data): one request per pixel in raster
// order; op = 1 marks a drain request with no pixel. After the last pixel of
// an image, width+1 drain requests flush the remaining results.
// Output channel (out_valid/out_ready/out_data): zero or one result per
// request, the rounded mean of the present neighbors; last_pixel marks the
// final result of the image, after which a new image starts.
// Config port (cfg_we/cfg_addr/cfg_wdata): image width and height; write only
// while idle, a write restarts the image.
// Pipeline: the s1, s2 and output registers follow the accepting edge of the
// request that completes a result's neighborhood (width+1 requests after its
// center pixel). Throughput: one request per cycle when not stalled, set by
// the single read and single write port of the line memory (read-modify-write
// with bypass). Reset: counters, window and output valid flag clear; width
// and height return to 1024; the line memory is not cleared and needs no
// clearing pass. Stall: while a result waits on out_ready the whole pipeline
// holds and in_ready is low.
`default_nettype none

module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  bblur_pkg::in_req_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output bblur_pkg::out_res_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [bblur_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PW    = bblur_pkg::PIX_W;

  logic [bblur_pkg::CFG_W-1:0]  image_width_r, image_height_r;
  logic [COL_W-1:0]             col_r, col_nxt;
  logic [ROW_W-1:0]             row_r, row_nxt;

  logic                         s1_valid_r;
  bblur_pkg::win_ctrl_t         s1_ctrl_r, s0_ctrl;
  bblur_pkg::rgb_t              s1_pix_r, s0_pix;
  logic [AW-1:0]                s1_addr_r, rd_addr;

  logic [2*bblur_pkg::RGB_W-1:0] line_mem [MAX_WIDTH];
  logic [2*bblur_pkg::RGB_W-1:0] rd_q_r, fwd_q_r, col_pair;
  logic                          fwd_r;
  bblur_pkg::rgb_t               col0, col1;
  bblur_pkg::rgb_t               win_r [6];

  logic                          s2_valid_r, s2_last_r;
  logic [bblur_pkg::NUM_W-1:0]   s2_num_r [3];
  logic [bblur_pkg::NUM_W-1:0]   s1_num [3];
  logic [bblur_pkg::CNT_W-1:0]   s2_cnt_r, s1_cnt;
  logic [bblur_pkg::PROD_W-1:0]  prod [3];

  logic                          out_valid_r;
  bblur_pkg::out_res_t           out_data_r;

  logic [31:0]      w_raw, h_raw, w_clamp, h_clamp, col_i, row_i, h_i;
  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic             adv, accept, in_image, skip, c_pos, wr_en, cfg_hit;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;
  assign cfg_hit  = cfg_we && (cfg_addr inside {bblur_pkg::REG_IMAGE_WIDTH,
                                                bblur_pkg::REG_IMAGE_HEIGHT});

  always_comb begin
    w_raw   = 32'(image_width_r);
    h_raw   = 32'(image_height_r);
    w_clamp = (w_raw == 32'd0) ? 32'd1 :
              ((w_raw > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : w_raw);
    h_clamp = (h_raw == 32'd0) ? 32'd1 :
              ((h_raw > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : h_raw);
    w_eff   = w_clamp[COL_W-1:0];
    h_eff   = h_clamp[ROW_W-1:0];
    col_i   = 32'(col_r);
    row_i   = 32'(row_r);
    h_i     = 32'(h_eff);
  end

  always_comb begin
    in_image          = row_i < h_i;
    skip              = in_data.op && in_image;
    c_pos             = col_i != 32'd0;
    s0_ctrl.emit      = (row_i >= 32'd2) || (row_i == 32'd1 && c_pos);
    s0_ctrl.has_left  = c_pos ? (col_i >= 32'd2) : (32'(w_eff) >= 32'd2);
    s0_ctrl.has_right = c_pos;
    s0_ctrl.top       = c_pos ? (row_i >= 32'd2) : (row_i >= 32'd3);
    s0_ctrl.bottom    = c_pos ? (row_i < h_i) : (row_i <= h_i);
    s0_ctrl.last      = !c_pos && (row_i == h_i + 32'd1);
    s0_pix            = in_image ? {in_data.red_in, in_data.green_in, in_data.blue_in}
                                 : '0;
    rd_addr           = col_r[AW-1:0];
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept && !skip) begin
      if (col_i + 32'd1 >= 32'(w_eff)) begin
        col_nxt = '0;
        row_nxt = ROW_W'(row_i + 32'd1);
      end else begin
        col_nxt = COL_W'(col_i + 32'd1);
      end
      if (s0_ctrl.emit && s0_ctrl.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= 11'd1024;
      image_height_r <= 11'd1024;
      col_r          <= '0;
      row_r          <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          bblur_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
          bblur_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // line memory: {upper, middle} row pixel per column
  assign col_pair = fwd_r ? fwd_q_r : rd_q_r;
  assign col0     = col_pair[2*bblur_pkg::RGB_W-1:bblur_pkg::RGB_W];
  assign col1     = col_pair[bblur_pkg::RGB_W-1:0];
  assign wr_en    = adv && s1_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[s1_addr_r] <= {col1, s1_pix_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_q_r  <= line_mem[rd_addr];
      fwd_q_r <= {col1, s1_pix_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctrl_r <= s0_ctrl;
      s1_pix_r  <= s0_pix;
      s1_addr_r <= rd_addr;
    end
  end

  always_comb begin
    bblur_pkg::rgb_t           px [3][3];
    logic [2:0]                cen, ren;
    logic [bblur_pkg::SUM_W-1:0] sum;
    px[0][0] = win_r[0];
    px[0][1] = win_r[1];
    px[0][2] = win_r[2];
    px[1][0] = win_r[3];
    px[1][1] = win_r[4];
    px[1][2] = win_r[5];
    px[2][0] = col0;
    px[2][1] = col1;
    px[2][2] = s1_pix_r;
    cen      = {s1_ctrl_r.has_right, 1'b1, s1_ctrl_r.has_left};
    ren      = {s1_ctrl_r.bottom, 1'b1, s1_ctrl_r.top};
    s1_cnt   = '0;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        if (cen[j] && ren[k]) begin
          s1_cnt = s1_cnt + 4'd1;
        end
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      sum = '0;
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          if (cen[j] && ren[k]) begin
            sum = sum + bblur_pkg::SUM_W'(px[j][k][PW*(2-ch) +: PW]);
          end
        end
      end
      s1_num[ch] = {sum, 1'b0} + bblur_pkg::NUM_W'(s1_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
      s2_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (adv) begin
      s1_valid_r  <= accept && !skip;
      fwd_r       <= s1_valid_r && (s1_addr_r == rd_addr);
      s2_valid_r  <= s1_valid_r && s1_ctrl_r.emit;
      out_valid_r <= s2_valid_r;
      if (s1_valid_r) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= col0;
        win_r[4] <= col1;
        win_r[5] <= s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last_r <= s1_ctrl_r.last;
      s2_cnt_r  <= s1_cnt;
      for (int ch = 0; ch < 3; ch++) begin
        s2_num_r[ch] <= s1_num[ch];
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = bblur_pkg::PROD_W'(s2_num_r[ch]) *
                 bblur_pkg::PROD_W'(bblur_pkg::recip(s2_cnt_r));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.red_out    <= prod[0][bblur_pkg::RCP_K +: PW];
      out_data_r.green_out  <= prod[1][bblur_pkg::RCP_K +: PW];
      out_data_r.blue_out   <= prod[2][bblur_pkg::RCP_K +: PW];
      out_data_r.last_pixel <= s2_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/bblur_checker.sv =====
`default_nettype none

module bblur_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bblur_pkg::out_res_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("not ready with empty output");

endmodule

bind box_blur_3x3_edge_aware bblur_checker u_bblur_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/box_blur_3x3_edge_aware_tb.sv =====
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware_tb;

  localparam int MAX_W          = 1024;
  localparam int MAX_H          = 1024;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEM_TARGET    = 1400;
  localparam logic OP_PIXEL     = 1'b0;
  localparam logic OP_DRAIN     = 1'b1;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  bblur_pkg::in_req_t   in_data;
  logic       out_valid;
  logic       out_ready;
  bblur_pkg::out_res_t  out_data;
  logic       cfg_we;
  logic [bblur_pkg::CFG_IDX_W-1:0] cfg_addr;
  logic [bblur_pkg::CFG_W-1:0]     cfg_wdata;

  int send_idle;
  int recv_stall;
  int hold_left = 0;
  int idle_cycles = 0;
  int sent_items = 0;

  always #5 clk = ~clk;

  box_blur_3x3_edge_aware #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  function automatic int unsigned clamp_dim(logic [bblur_pkg::CFG_W-1:0] v,
                                            int unsigned maxv);
    if (v == '0) return 1;
    if (32'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  class blur_scoreboard;
    logic [bblur_pkg::CFG_W-1:0] width_reg;
    logic [bblur_pkg::CFG_W-1:0] height_reg;
    bblur_pkg::rgb_t     upper_line [MAX_W];
    bblur_pkg::rgb_t     middle_line [MAX_W];
    bblur_pkg::rgb_t     window [6];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned acc_r, acc_g, acc_b, acc_n;
    bblur_pkg::out_res_t blurred_due [$];
    int          errors;

    function new();
      width_reg  = 11'd1024;
      height_reg = 11'd1024;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      col_pos = 0;
      row_pos = 0;
      errors  = 0;
    endfunction

    function void write_reg(bblur_pkg::cfg_reg_t idx, logic [bblur_pkg::CFG_W-1:0] v);
      case (idx)
        bblur_pkg::REG_IMAGE_WIDTH: begin
          width_reg = v;
          col_pos   = 0;
          row_pos   = 0;
        end
        bblur_pkg::REG_IMAGE_HEIGHT: begin
          height_reg = v;
          col_pos    = 0;
          row_pos    = 0;
        end
        default: ;
      endcase
    endfunction

    function void add_px(bblur_pkg::rgb_t p);
      acc_r += p[23:16];
      acc_g += p[15:8];
      acc_b += p[7:0];
      acc_n++;
    endfunction

    function void add_col(bblur_pkg::rgb_t t, bblur_pkg::rgb_t m, bblur_pkg::rgb_t b,
                          bit top, bit bottom);
      if (top) add_px(t);
      add_px(m);
      if (bottom) add_px(b);
    endfunction

    function void note_request(bblur_pkg::in_req_t rq);
      int unsigned w, h, c, r, cr, cc;
      bit in_img, has_l, has_r, top, bottom, emitted;
      bblur_pkg::rgb_t newpix, t, m;
      bblur_pkg::out_res_t res;
      w = clamp_dim(width_reg, MAX_W);
      h = clamp_dim(height_reg, MAX_H);
      in_img = (row_pos * w + col_pos) < (w * h);
      emitted = 1'b0;
      res = '0;
      // drop a drain that arrives before the last pixel
      if (rq.op == OP_DRAIN && in_img) return;
      newpix = (in_img) ? {rq.red_in, rq.green_in, rq.blue_in} : '0;
      c = col_pos;
      r = row_pos;
      t = upper_line[c];
      m = middle_line[c];
      upper_line[c]  = m;
      middle_line[c] = newpix;
      if (r >= 2 || (r == 1 && c >= 1)) begin
        if (c >= 1) begin
          cr = r - 1;
          cc = c - 1;
          has_l = (cc >= 1);
          has_r = 1'b1;
        end else begin
          cr = r - 2;
          cc = w - 1;
          has_l = (w >= 2);
          has_r = 1'b0;
        end
        top    = (cr >= 1);
        bottom = (cr + 1) < h;
        acc_r = 0;
        acc_g = 0;
        acc_b = 0;
        acc_n = 0;
        if (has_l) add_col(window[0], window[1], window[2], top, bottom);
        add_col(window[3], window[4], window[5], top, bottom);
        if (has_r) add_col(t, m, newpix, top, bottom);
        res.red_out    = 8'((2 * acc_r + acc_n) / (2 * acc_n));
        res.green_out  = 8'((2 * acc_g + acc_n) / (2 * acc_n));
        res.blue_out   = 8'((2 * acc_b + acc_n) / (2 * acc_n));
        res.last_pixel = (cr == h - 1) && (cc == w - 1);
        blurred_due.push_back(res);
        emitted = 1'b1;
      end
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = t;
      window[4] = m;
      window[5] = newpix;
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
      end
      if (emitted && res.last_pixel) begin
        col_pos = 0;
        row_pos = 0;
      end
    endfunction

    function void check_result(bblur_pkg::out_res_t got);
      bblur_pkg::out_res_t want;
      if (blurred_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result r=%0d g=%0d b=%0d last=%0b",
                   got.red_out, got.green_out, got.blue_out, got.last_pixel);
        return;
      end
      want = blurred_due.pop_front();
      if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
          got.blue_out !== want.blue_out || got.last_pixel !== want.last_pixel) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                   want.red_out, want.green_out, want.blue_out, want.last_pixel,
                   got.red_out, got.green_out, got.blue_out, got.last_pixel);
      end
    endfunction
  endclass

  blur_scoreboard blur_sb;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) blur_sb.note_request(in_data);
      if (out_valid && out_ready) blur_sb.check_result(out_data);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall);
      end
    end
  end

  function automatic bblur_pkg::in_req_t mk_req(logic op, logic [7:0] r, logic [7:0] g,
                                                logic [7:0] b);
    bblur_pkg::in_req_t rq;
    rq.op       = op;
    rq.red_in   = r;
    rq.green_in = g;
    rq.blue_in  = b;
    return rq;
  endfunction

  function automatic logic [7:0] rand_level();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic bblur_pkg::in_req_t rand_req(logic op);
    return mk_req(op, rand_level(), rand_level(), rand_level());
  endfunction

  task automatic set_phase(int k);
    case (k)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 47; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 47; end
      default: begin send_idle = 38; recv_stall = 38; end
    endcase
  endtask

  task automatic send_request(bblur_pkg::in_req_t rq);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = rq;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (blur_sb.blurred_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(bblur_pkg::cfg_reg_t idx, logic [bblur_pkg::CFG_W-1:0] v);
    in_valid  = 1'b0;
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = v;
    blur_sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic stall_receiver(int n);
    in_valid = 1'b0;
    @(posedge clk);
    hold_left = n;
    @(negedge clk);
  endtask

  task automatic run_image(int unsigned w, int unsigned h, bit abandon, bit pause_mid);
    int unsigned npix, cut, k;
    npix = w * h;
    cut  = abandon ? $urandom_range(npix - 1) : npix;
    for (k = 0; k < cut; k++) begin
      if ($urandom_range(99) < 8) send_request(rand_req(OP_DRAIN));
      send_request(rand_req(OP_PIXEL));
      sent_items++;
      // hold the sender until the block has caught up
      if (pause_mid && k == cut / 2) wait_drained();
    end
    if (abandon) begin
      wait_drained();
    end else begin
      for (k = 0; k <= w; k++) begin
        if ($urandom_range(99) < 15)
          send_request(rand_req(OP_PIXEL));
        else
          send_request(rand_req(OP_DRAIN));
        sent_items++;
      end
    end
  endtask

  initial begin
    int unsigned k, img;
    logic [bblur_pkg::CFG_W-1:0] wv, hv;
    bit abandon, pause, must_write;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = bblur_pkg::REG_IMAGE_WIDTH;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    blur_sb   = new();
    set_phase(0);
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // start an image at reset size, then abandon it
    for (k = 0; k < 3; k++) send_request(mk_req(OP_PIXEL, 8'hFF, 8'h00, 8'h80));
    wait_drained();
    write_reg(bblur_pkg::REG_IMAGE_WIDTH, 11'd3);
    write_reg(bblur_pkg::REG_IMAGE_HEIGHT, 11'd3);
    send_request(mk_req(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF));
    for (k = 0; k < 9; k++)
      send_request(mk_req(OP_PIXEL, k[0] ? 8'hFF : 8'h00, k[0] ? 8'h00 : 8'hFF,
                          8'(k * 29)));
    send_request(mk_req(OP_DRAIN, 8'h00, 8'h00, 8'h00));
    send_request(mk_req(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF));
    send_request(mk_req(OP_DRAIN, 8'h00, 8'h00, 8'h00));
    send_request(mk_req(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF));
    send_request(mk_req(OP_DRAIN, 8'h55, 8'hAA, 8'h55));
    wait_drained();
    write_reg(bblur_pkg::REG_IMAGE_WIDTH, 11'd0);
    write_reg(bblur_pkg::REG_IMAGE_HEIGHT, 11'd0);
    send_request(mk_req(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF));
    send_request(mk_req(OP_DRAIN, 8'h00, 8'h00, 8'h00));
    send_request(mk_req(OP_DRAIN, 8'h00, 8'h00, 8'h00));
    wait_drained();
    write_reg(bblur_pkg::REG_IMAGE_WIDTH, 11'd2);
    write_reg(bblur_pkg::REG_IMAGE_HEIGHT, 11'd1);
    send_request(mk_req(OP_PIXEL, 8'h01, 8'hFE, 8'h7F));
    send_request(mk_req(OP_PIXEL, 8'hFE, 8'h01, 8'h80));
    for (k = 0; k < 3; k++) send_request(mk_req(OP_DRAIN, 8'h00, 8'h00, 8'h00));

    // widest image: wrap a full row, then abandon it
    wait_drained();
    set_phase(3);
    write_reg(bblur_pkg::REG_IMAGE_WIDTH, 11'h7FF);
    write_reg(bblur_pkg::REG_IMAGE_HEIGHT, 11'h7FF);
    for (k = 0; k < MAX_W + 8; k++) begin
      send_request(rand_req(OP_PIXEL));
      sent_items++;
    end

    // back up the output while the sender keeps offering
    wait_drained();
    set_phase(0);
    wv = 11'd8;
    hv = 11'd6;
    write_reg(bblur_pkg::REG_IMAGE_WIDTH, wv);
    write_reg(bblur_pkg::REG_IMAGE_HEIGHT, hv);
    stall_receiver(200);
    run_image(8, 6, 1'b0, 1'b1);

    img = 0;
    must_write = 1'b1;
    while (sent_items < ITEM_TARGET) begin
      set_phase(img % 4);
      img++;
      if (must_write || $urandom_range(2) == 0) begin
        wv = 11'($urandom_range(10));
        hv = 11'($urandom_range(7));
        if ($urandom_range(7) == 0) wv = 11'($urandom_range(40, 11));
        wait_drained();
        write_reg(bblur_pkg::REG_IMAGE_WIDTH, wv);
        write_reg(bblur_pkg::REG_IMAGE_HEIGHT, hv);
      end
      abandon = ($urandom_range(99) < 12);
      pause   = ($urandom_range(99) < 10);
      run_image(clamp_dim(wv, MAX_W), clamp_dim(hv, MAX_H), abandon, pause);
      must_write = abandon;
    end

    wait_drained();
    if (blur_sb.errors == 0 && blur_sb.blurred_due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
